// ===== hdl/lkv_pkg.sv =====
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // A get that misses returns all ones, that is -1.
  localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } lkv_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_COMMIT
  } lkv_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } lkv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } lkv_sts_t;

endpackage

// ===== hdl/lkv_if.sv =====
`timescale 1ns / 1ps

interface lkv_in_if;
  logic                valid;
  logic                ready;
  logic [0:0]          operation;
  logic signed [31:0]  key;
  logic signed [31:0]  value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink (input valid, input operation, input key, input value, output ready);
endinterface

interface lkv_out_if;
  logic                valid;
  logic                ready;
  logic [0:0]          hit;
  logic signed [31:0]  read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink (input valid, input hit, input read_value, output ready);
endinterface

// ===== hdl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Handshake       Payload
// in_ch      in         valid/ready     operation, key, value
// out_ch     out        valid/ready     hit, read_value
// cfg        in         cfg_wr_en       cfg_wr_data (capacity)
//
// Each item is captured, its key is scanned against every entry through the
// single read port of the table memory, the last compare is finished and the
// item is committed; a new item is taken only after the commit.
// The result sits in an output register; a stalled output holds the commit.
// Reset clears the valid bits, recency ranks and entry count at once.

module lru_key_value_cache #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data,
  lkv_in_if.sink                    in_ch,
  lkv_out_if.source                 out_ch
);
  import lkv_pkg::*;

  lkv_cmd_t cmd;
  lkv_sts_t sts;

  // The controller sequences capture, scan, flush and commit; it only accepts
  // an item when the previous one has been committed.
  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the table memory, valid bits, recency ranks, the
  // capacity register and the output register.
  lkv_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_operation   (in_ch.operation),
    .in_key         (in_ch.key),
    .in_value       (in_ch.value),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_hit        (out_ch.hit),
    .out_read_value (out_ch.read_value)
  );

endmodule

// ===== hdl/lkv_ctrl.sv =====
`timescale 1ns / 1ps

module lkv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lkv_pkg::lkv_sts_t sts,
  output lkv_pkg::lkv_cmd_t cmd
);
  import lkv_pkg::*;

  lkv_state_t state;
  lkv_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
      end
      ST_FLUSH: begin
      end
      ST_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/lkv_dp.sv =====
`timescale 1ns / 1ps

module lkv_dp #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0]     cfg_wr_data,
  input  logic [0:0]                    in_operation,
  input  logic signed [lkv_pkg::KEY_W-1:0]   in_key,
  input  logic signed [lkv_pkg::VALUE_W-1:0] in_value,
  input  lkv_pkg::lkv_cmd_t             cmd,
  output lkv_pkg::lkv_sts_t             sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [0:0]                    out_hit,
  output logic signed [lkv_pkg::VALUE_W-1:0] out_read_value
);
  import lkv_pkg::*;

  localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int RW   = IW;
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  // Key and value of each entry share one word of the table memory.
  logic [KEY_W+VALUE_W-1:0] mem [TABLE_ENTRIES];
  logic [KEY_W+VALUE_W-1:0] mem_q;

  logic [CAP_W-1:0]   capacity;
  logic               op_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] val_r;

  logic [IW-1:0]      idx;
  logic               cmp_en;
  logic [IW-1:0]      cmp_idx;

  logic               found;
  logic [IW-1:0]      slot;
  logic [VALUE_W-1:0] found_val;
  logic               free_found;
  logic [IW-1:0]      free_slot;
  logic [IW-1:0]      lru_slot;

  logic [TABLE_ENTRIES-1:0] valid;
  logic [RW-1:0]      rank [TABLE_ENTRIES];
  logic [CW-1:0]      held;

  logic [CMPW-1:0]    cap_ext;
  logic [CMPW-1:0]    cap_eff;
  logic [RW-1:0]      held_m1;
  logic               room;
  logic               fill;
  logic               touch_en;
  logic [IW-1:0]      wr_slot;
  logic [RW-1:0]      touch_rank;
  logic               key_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Capacity zero counts as one; anything above the table size saturates.
  always_comb begin
    cap_ext = CMPW'(capacity);
    if (capacity == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_ext > CMPW'(TABLE_ENTRIES)) begin
      cap_eff = CMPW'(TABLE_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign held_m1    = RW'(held - CW'(1));
  assign room       = CMPW'(held) < cap_eff;
  assign fill       = (op_r == OP_SET) && !found && room;
  assign touch_en   = found || ((op_r == OP_SET) && !room);
  assign wr_slot    = found ? slot : (room ? free_slot : lru_slot);
  assign touch_rank = rank[wr_slot];
  assign key_match  = valid[cmp_idx] && (mem_q[KEY_W+VALUE_W-1:VALUE_W] == key_r);

  always_ff @(posedge clk) begin
    if (cmd.commit && (op_r == OP_SET)) begin
      mem[wr_slot] <= {key_r, val_r};
    end
    if (cmd.step) begin
      mem_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.step;
    end
  end

  // Scan: the read issued at one step is compared in the cycle after it.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_operation[0];
      key_r      <= in_key;
      val_r      <= in_value;
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end
    if (cmd.step) begin
      idx     <= idx + IW'(1);
      cmp_idx <= idx;
    end
    if (cmp_en) begin
      if (key_match && !found) begin
        found     <= 1'b1;
        slot      <= cmp_idx;
        found_val <= mem_q[VALUE_W-1:0];
      end
      if (!valid[cmp_idx] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= cmp_idx;
      end
      if (valid[cmp_idx] && (rank[cmp_idx] == held_m1)) begin
        lru_slot <= cmp_idx;
      end
    end
  end

  // Recency ranks form a permutation of 0 .. held-1 over the valid entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      held  <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (touch_en) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (IW'(i) == wr_slot) begin
            rank[i] <= '0;
          end else if (valid[i] && (rank[i] < touch_rank)) begin
            rank[i] <= rank[i] + RW'(1);
          end
        end
      end else if (fill) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (IW'(i) == free_slot) begin
            rank[i] <= '0;
          end else if (valid[i]) begin
            rank[i] <= rank[i] + RW'(1);
          end
        end
        valid[free_slot] <= 1'b1;
        held             <= held + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit <= found;
      if (op_r == OP_SET) begin
        out_read_value <= val_r;
      end else if (found) begin
        out_read_value <= found_val;
      end else begin
        out_read_value <= MISS_VALUE;
      end
    end
  end

  assign sts.scan_last = (idx == IW'(TABLE_ENTRIES - 1));
  assign sts.out_free  = !out_valid || out_ready;

  a_held_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(held))
    else $error("entry count differs from number of valid entries");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result register empty after commit");

  a_fill_grows_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && fill) |=> (held == $past(held) + CW'(1)))
    else $error("fill of a free entry did not raise the entry count");

endmodule
